/* rtl/lsrb_pkg.sv */
package lsrb_pkg;

	localparam logic [1:0] ACT_WRITE   = 2'd0;
	localparam logic [1:0] ACT_READ    = 2'd1;
	localparam logic [1:0] ACT_RELEASE = 2'd2;

	localparam logic [1:0] OVR_NONE   = 2'd0;
	localparam logic [1:0] OVR_NEWEST = 2'd1;
	localparam logic [1:0] OVR_OLDEST = 2'd2;

	localparam logic [7:0] NEWLINE = 8'h0A;
	localparam logic [7:0] NUL     = 8'h00;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
		logic [4:0] read_offset;
	} item_t;

	typedef struct packed {
		logic       ready_res;
		logic [7:0] read_byte;
		logic       advanced;
		logic [1:0] overrun;
	} result_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	typedef struct packed {
		logic       ready_res;
		logic       rd_hit;
		logic       advanced;
		logic [1:0] overrun;
	} step_res_t;

endpackage

/* rtl/lsrb_mem.sv */
module lsrb_mem
	import lsrb_pkg::*;
#(
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  mem_ctl_t      ctl,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/lsrb_ctrl.sv */
module lsrb_ctrl
	import lsrb_pkg::*;
#(
	parameter int SLOTS = 8,
	parameter int SLOT_LEN = 32,
	localparam int AW = $clog2(SLOTS * SLOT_LEN)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  item_t         item,
	input  logic          policy,
	output mem_ctl_t      mem_ctl,
	output logic [AW-1:0] mem_addr,
	output logic [7:0]    mem_wdata,
	output step_res_t     res
);

	localparam int SW = $clog2(SLOTS);
	localparam int LW = $clog2(SLOT_LEN);
	localparam int CW = (LW > 5) ? LW : 5;

	logic          filled_q [SLOTS];
	logic [LW-1:0] len_q [SLOTS];
	logic [SW-1:0] head_q;
	logic [SW-1:0] tail_q;
	logic [LW-1:0] count_q;

	logic          filled_d [SLOTS];
	logic [LW-1:0] len_d [SLOTS];
	logic [SW-1:0] head_d;
	logic [SW-1:0] tail_d;
	logic [LW-1:0] count_d;

	logic [SW-1:0] head_nxt;
	logic [SW-1:0] tail_nxt;
	logic [LW-1:0] count_inc;
	logic          close;
	logic          wr;
	logic          rd;
	logic [SW-1:0] addr_slot;
	logic [LW-1:0] addr_idx;

	function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
		next_slot = (s == SW'(SLOTS - 1)) ? '0 : s + 1'b1;
	endfunction

	assign head_nxt  = next_slot(head_q);
	assign tail_nxt  = next_slot(tail_q);
	assign count_inc = count_q + 1'b1;
	assign close     = (item.data_byte == NEWLINE) || (count_inc == LW'(SLOT_LEN - 1));

	always_comb begin
		filled_d  = filled_q;
		len_d     = len_q;
		head_d    = head_q;
		tail_d    = tail_q;
		count_d   = count_q;
		wr        = 1'b0;
		rd        = 1'b0;
		addr_slot = tail_q;
		addr_idx  = LW'(item.read_offset);
		res       = '0;
		unique case (item.action)
			ACT_WRITE: begin
				wr        = 1'b1;
				addr_slot = head_q;
				addr_idx  = count_q;
				count_d   = count_inc;
				if (close) begin
					filled_d[head_q] = 1'b1;
					len_d[head_q]    = count_inc;
					count_d          = '0;
					if ((head_nxt == tail_q) && !policy) begin
						filled_d[head_q] = 1'b0;
						len_d[head_q]    = '0;
						res.overrun      = OVR_NEWEST;
					end else begin
						if (head_nxt == tail_q) begin
							filled_d[tail_q] = 1'b0;
							len_d[tail_q]    = '0;
							if (tail_nxt != head_q) begin
								tail_d = tail_nxt;
							end
							res.overrun = OVR_OLDEST;
						end
						head_d             = head_nxt;
						filled_d[head_nxt] = 1'b0;
						len_d[head_nxt]    = '0;
					end
				end
			end
			ACT_READ: begin
				rd         = 1'b1;
				res.rd_hit = filled_q[tail_q]
					&& (CW'(item.read_offset) < CW'(len_q[tail_q]));
			end
			ACT_RELEASE: begin
				filled_d[tail_q] = 1'b0;
				len_d[tail_q]    = '0;
				if (tail_nxt != head_q) begin
					tail_d       = tail_nxt;
					res.advanced = 1'b1;
				end
			end
			default: begin
			end
		endcase
		res.ready_res = filled_d[tail_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= SW'(SLOTS - 1);
			count_q <= '0;
			for (int i = 0; i < SLOTS; i++) begin
				filled_q[i] <= 1'b0;
				len_q[i]    <= '0;
			end
		end else if (step) begin
			head_q   <= head_d;
			tail_q   <= tail_d;
			count_q  <= count_d;
			filled_q <= filled_d;
			len_q    <= len_d;
		end
	end

	assign mem_ctl.wr_en = step & wr;
	assign mem_ctl.rd_en = step & rd;
	assign mem_addr      = AW'(addr_slot) * AW'(SLOT_LEN) + AW'(addr_idx);
	assign mem_wdata     = item.data_byte;

endmodule

/* rtl/line_slot_ring_buffer_core.sv */
// An accepted item beat is held in item_s1; when it steps, its result beat is registered in res_s2 and offered.
// Throughput: one item per cycle while res_stall is low; each item makes at most one access to the byte memory.
// Reset clears the head pointer, sets the tail pointer to the last slot,
// clears the fill count, every slot's closed flag and length, and the overwrite
// policy; the byte memory is not cleared and needs no clearing pass, so items are taken right after reset.
module line_slot_ring_buffer_core
	import lsrb_pkg::*;
#(
	parameter int SLOTS = 8,
	parameter int SLOT_LEN = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    res_valid,
	input  logic    res_stall,
	output result_t res,
	input  logic    cfg_valid,
	output logic    cfg_ready,
	input  logic    cfg_data
);

	localparam int AW = $clog2(SLOTS * SLOT_LEN);

	logic          policy_q;
	item_t         item_s1;
	logic          vld_s1;
	step_res_t     res_s2;
	logic          vld_s2;
	logic          step;
	step_res_t     step_res;
	mem_ctl_t      mem_ctl;
	logic [AW-1:0] mem_addr;
	logic [7:0]    mem_wdata;
	logic [7:0]    mem_rdata;

	assign step       = vld_s1 && (!vld_s2 || !res_stall);
	assign item_stall = vld_s1 && !step;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= 1'b0;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				policy_q <= cfg_data;
			end
			if (!item_stall) begin
				vld_s1 <= item_valid;
			end
			if (step) begin
				vld_s2 <= 1'b1;
			end else if (!res_stall) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			item_s1 <= item;
		end
		if (step) begin
			res_s2 <= step_res;
		end
	end

	lsrb_ctrl #(
		.SLOTS(SLOTS),
		.SLOT_LEN(SLOT_LEN)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.step(step),
		.item(item_s1),
		.policy(policy_q),
		.mem_ctl(mem_ctl),
		.mem_addr(mem_addr),
		.mem_wdata(mem_wdata),
		.res(step_res)
	);

	lsrb_mem #(
		.DEPTH(SLOTS * SLOT_LEN)
	) u_mem (
		.clk(clk),
		.ctl(mem_ctl),
		.addr(mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	assign res_valid     = vld_s2;
	assign res.ready_res = res_s2.ready_res;
	assign res.read_byte = res_s2.rd_hit ? mem_rdata : NUL;
	assign res.advanced  = res_s2.advanced;
	assign res.overrun   = res_s2.overrun;

`ifndef SYNTHESIS
	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> res_valid)
		else $error("accepted step did not produce a result");

	a_read_needs_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.read_byte != NUL) |-> res.ready_res)
		else $error("byte returned from a slot that is not ready");

	a_adv_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.advanced) |-> (res.overrun == OVR_NONE))
		else $error("advance and overrun reported together");

	a_overrun_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.overrun == OVR_NONE || res.overrun == OVR_NEWEST
			|| res.overrun == OVR_OLDEST))
		else $error("illegal overrun code");
`endif

endmodule
